FILE: rtl/rc5_pkg.sv
// ----------------------------------------------------------------------------
// rc5_pkg
// shared types, codes and word helpers for the rc5-32 encryption chain
// ----------------------------------------------------------------------------
package rc5_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_IDX_W = 6;
    localparam int unsigned ROT_W     = 5;

    // opcode values
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    // one beat travelling down the chain
    typedef struct packed {
        logic                 enc;   // encrypt beat, produces a result at the end
        logic                 load;  // key load beat, written by the matching cell
        logic [KEY_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    word;  // key word, already byte-swapped
        logic [WORD_W-1:0]    x;     // word being updated next
        logic [WORD_W-1:0]    y;     // word used as rotate amount
    } t_beat;

    function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                  input logic [ROT_W-1:0]  n);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << n;
        return d[2*WORD_W-1:WORD_W];
    endfunction

endpackage

FILE: rtl/rc5_front.sv
// ----------------------------------------------------------------------------
// rc5_front
// entry cell: byte swap, key words 0 and 1, pre-whitening add
// ----------------------------------------------------------------------------
module rc5_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  logic                             i_opcode,
    input  logic [rc5_pkg::KEY_IDX_W-1:0]    i_key_index,
    input  logic [rc5_pkg::WORD_W-1:0]       i_key_word,
    input  logic [rc5_pkg::WORD_W-1:0]       i_a_in,
    input  logic [rc5_pkg::WORD_W-1:0]       i_b_in,
    output rc5_pkg::t_beat                   o_beat
);
    import rc5_pkg::*;

    localparam logic [KEY_IDX_W-1:0] IDX_S0 = KEY_IDX_W'(0);
    localparam logic [KEY_IDX_W-1:0] IDX_S1 = KEY_IDX_W'(1);

    logic              r_enc;
    logic              r_load;
    logic [KEY_IDX_W-1:0] r_idx;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_s0;
    logic [WORD_W-1:0] r_s1;
    logic [WORD_W-1:0] n_word;
    logic              n_load;

    assign n_word = bswap32(i_key_word);
    assign n_load = i_valid && (i_opcode == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc  <= 1'b0;
            r_load <= 1'b0;
        end else if (i_adv) begin
            r_enc  <= i_valid && (i_opcode == OP_ENCRYPT);
            r_load <= n_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx  <= i_key_index;
            r_word <= n_word;
            r_x    <= bswap32(i_a_in) + r_s0;
            r_y    <= bswap32(i_b_in) + r_s1;
            if (n_load && i_key_index == IDX_S0) begin
                r_s0 <= n_word;
            end
            if (n_load && i_key_index == IDX_S1) begin
                r_s1 <= n_word;
            end
        end
    end

    assign o_beat = '{enc: r_enc, load: r_load, idx: r_idx, word: r_word, x: r_x, y: r_y};

endmodule

FILE: rtl/rc5_cell.sv
// ----------------------------------------------------------------------------
// rc5_cell
// one half round: holds one key word, x = rotl(x ^ y, y) + key, roles swap
// ----------------------------------------------------------------------------
module rc5_cell #(
    parameter int unsigned KEY_IDX = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  rc5_pkg::t_beat i_beat,
    output rc5_pkg::t_beat o_beat
);
    import rc5_pkg::*;

    localparam logic [KEY_IDX_W-1:0] MY_IDX = KEY_IDX_W'(KEY_IDX);

    logic                 r_enc;
    logic                 r_load;
    logic [KEY_IDX_W-1:0] r_idx;
    logic [WORD_W-1:0]    r_word;
    logic [WORD_W-1:0]    r_x;
    logic [WORD_W-1:0]    r_y;
    logic [WORD_W-1:0]    r_key;
    logic [WORD_W-1:0]    n_y;

    assign n_y = rotl32(i_beat.x ^ i_beat.y, i_beat.y[ROT_W-1:0]) + r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc  <= 1'b0;
            r_load <= 1'b0;
        end else if (i_adv) begin
            r_enc  <= i_beat.enc;
            r_load <= i_beat.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx  <= i_beat.idx;
            r_word <= i_beat.word;
            // updated word becomes next cell's rotate source
            r_x    <= i_beat.y;
            r_y    <= n_y;
            if (i_beat.load && i_beat.idx == MY_IDX) begin
                r_key <= i_beat.word;
            end
        end
    end

    assign o_beat = '{enc: r_enc, load: r_load, idx: r_idx, word: r_word, x: r_x, y: r_y};

endmodule

FILE: rtl/rc5_block_encrypt.sv
// ----------------------------------------------------------------------------
// rc5_block_encrypt
// rc5-32 block encryption as a chain of half-round cells
// ----------------------------------------------------------------------------
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_stall | i_opcode i_key_index i_key_word i_a_in i_b_in
//  output  | o_valid | i_stall | o_a_out o_b_out
//
//  one beat enters per cycle unless the chain is stalled; an encrypt beat
//  is registered in the entry cell and then in one cell per half round
//  a load beat walks the chain and is written by the cell owning its index,
//  so loads and encrypts keep their order; a load gives no output beat
//  reset clears beat valid flags only, key words are undefined until loaded
//  the whole chain holds while an output beat is stalled
// ----------------------------------------------------------------------------
module rc5_block_encrypt #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [rc5_pkg::KEY_IDX_W-1:0] i_key_index,
    input  logic [rc5_pkg::WORD_W-1:0]    i_key_word,
    input  logic [rc5_pkg::WORD_W-1:0]    i_a_in,
    input  logic [rc5_pkg::WORD_W-1:0]    i_b_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rc5_pkg::WORD_W-1:0]    o_a_out,
    output logic [rc5_pkg::WORD_W-1:0]    o_b_out
);
    import rc5_pkg::*;

    // one cell per half round, key words 2 .. 2*ROUNDS+1
    localparam int unsigned N_CELLS = 2 * ROUNDS;

    t_beat beat [0:N_CELLS];
    logic  adv;

    // chain moves unless a finished beat is held at the output
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    rc5_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_key_index (i_key_index),
        .i_key_word  (i_key_word),
        .i_a_in      (i_a_in),
        .i_b_in      (i_b_in),
        .o_beat      (beat[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        rc5_cell #(
            .KEY_IDX (g + 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_beat  (beat[g]),
            .o_beat  (beat[g+1])
        );
    end

    // after an even number of half rounds x holds a and y holds b
    assign o_valid = beat[N_CELLS].enc;
    assign o_a_out = bswap32(beat[N_CELLS].x);
    assign o_b_out = bswap32(beat[N_CELLS].y);

    // a beat is never both a load and an encrypt
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(beat[0].enc && beat[0].load))
        else $error("entry beat flagged as both load and encrypt");

    // a held output beat must stall the input side
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input accepted while output beat held");

    // reset empties the chain
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !beat[0].enc && !beat[0].load)
        else $error("chain not empty after reset");

    // while stalled the last stage keeps its beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output beat lost during stall");

endmodule

FILE: tb/sv/tb_rc5_block_encrypt.sv
// ----------------------------------------------------------------------------
// tb_rc5_block_encrypt
// self-checking bench for the rc5-32 encryption chain: fills the key table,
// runs directed and random load/encrypt beats through a valid/stall driver,
// predicts each ciphertext block in order and compares every output beat
// ----------------------------------------------------------------------------
module tb_rc5_block_encrypt;

    import rc5_pkg::*;

    localparam int unsigned ROUNDS      = 12;
    localparam int unsigned KEY_DEPTH   = 2 * ROUNDS + 2;
    localparam int unsigned N_ITEMS     = 1800;
    localparam int unsigned TAIL_CYCLES = 400;      // pipe depth plus worst stall, with margin
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // one pending command for the driver; a drain marker makes it pause
    typedef struct {
        logic                 op;
        logic [KEY_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    kw;
        logic [WORD_W-1:0]    a;
        logic [WORD_W-1:0]    b;
        bit                   drain;
    } t_block_cmd;

    // one predicted ciphertext block
    typedef struct {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_cipher;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_opcode    = OP_LOAD;
    logic [KEY_IDX_W-1:0] i_key_index = '0;
    logic [WORD_W-1:0]    i_key_word  = '0;
    logic [WORD_W-1:0]    i_a_in      = '0;
    logic [WORD_W-1:0]    i_b_in      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [WORD_W-1:0]    o_a_out;
    logic [WORD_W-1:0]    o_b_out;

    t_block_cmd        cmd_fifo[$];     // beats still to be offered
    t_cipher           cipher_fifo[$];  // ciphertext owed by the block, oldest first
    logic [WORD_W-1:0] key_sched[KEY_DEPTH];  // expanded key, byte-swapped as stored

    int unsigned err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int          gap_left  = 0;
    int          stall_left = 0;
    int          tx_calm   = 0;
    int          rx_calm   = 0;

    rc5_block_encrypt #(
        .ROUNDS (ROUNDS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_key_index (i_key_index),
        .i_key_word  (i_key_word),
        .i_a_in      (i_a_in),
        .i_b_in      (i_b_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_a_out     (o_a_out),
        .o_b_out     (o_b_out)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // word helpers and the block predictor
    // ------------------------------------------------------------------------

    // memory byte order <-> working order
    function automatic logic [WORD_W-1:0] byte_reverse(input logic [WORD_W-1:0] v);
        return {<<8{v}};
    endfunction

    function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] v,
                                                      input logic [4:0]        n);
        if (n == 0) return v;
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // full encryption of one block under the current key schedule
    function automatic t_cipher encrypt_block(input logic [WORD_W-1:0] pa,
                                              input logic [WORD_W-1:0] pb);
        logic [WORD_W-1:0] wa;
        logic [WORD_W-1:0] wb;
        t_cipher           c;
        wa = byte_reverse(pa) + key_sched[0];
        wb = byte_reverse(pb) + key_sched[1];
        for (int r = 1; r <= ROUNDS; r++) begin
            wa = rotate_left(wa ^ wb, wb[4:0]) + key_sched[2*r];
            wb = rotate_left(wb ^ wa, wa[4:0]) + key_sched[2*r+1];
        end
        c.a = byte_reverse(wa);
        c.b = byte_reverse(wb);
        return c;
    endfunction

    // idle length for either side: mostly none or short, a few long,
    // and now and then a calm stretch with no idling at all
    function automatic int draw_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2) begin
            calm = $urandom_range(200, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic push_cmd(input logic op, input logic [KEY_IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] kw, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b);
        t_block_cmd c;
        c.op    = op;
        c.idx   = idx;
        c.kw    = kw;
        c.a     = a;
        c.b     = b;
        c.drain = 1'b0;
        cmd_fifo.push_back(c);
    endtask

    task automatic push_drain();
        t_block_cmd c;
        c       = '{default: '0};
        c.drain = 1'b1;
        cmd_fifo.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued beats, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_block_cmd nxt;
        logic       drive;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            drive = i_valid;
            // beat taken at this edge: update the model with what was on the pins
            if (i_valid && !o_stall) begin
                if (i_opcode == OP_ENCRYPT) begin
                    cipher_fifo.push_back(encrypt_block(i_a_in, i_b_in));
                end else if (i_key_index < KEY_DEPTH) begin
                    key_sched[i_key_index] = byte_reverse(i_key_word);
                end
                // indexes past the table are dropped by the block
                drive = 1'b0;
            end
            // a stalled beat stays on the pins untouched
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_fifo.size() != 0) begin
                    if (cmd_fifo[0].drain) begin
                        // hold off until every owed block has come out
                        if (cipher_fifo.size() == 0) void'(cmd_fifo.pop_front());
                    end else begin
                        nxt         = cmd_fifo.pop_front();
                        i_opcode    <= nxt.op;
                        i_key_index <= nxt.idx;
                        i_key_word  <= nxt.kw;
                        i_a_in      <= nxt.a;
                        i_b_in      <= nxt.b;
                        drive       = 1'b1;
                        gap_left    = draw_pause(tx_calm);
                    end
                end
            end
            i_valid <= drive;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, compares each output beat in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cipher exp_blk;
        int      n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (cipher_fifo.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected beat, expected none, got a=%h b=%h",
                             $time, o_a_out, o_b_out);
                end else begin
                    exp_blk = cipher_fifo.pop_front();
                    if (o_a_out !== exp_blk.a) begin
                        err_cnt++;
                        $display("%0t: a_out mismatch, expected %h, got %h",
                                 $time, exp_blk.a, o_a_out);
                    end
                    if (o_b_out !== exp_blk.b) begin
                        err_cnt++;
                        $display("%0t: b_out mismatch, expected %h, got %h",
                                 $time, exp_blk.b, o_b_out);
                    end
                end
            end
            // stall runs are drawn independently of o_valid
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                n = draw_pause(rx_calm);
                if (n > 0) begin
                    stall_left = n - 1;
                    i_stall    <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned       n_queued;
        int                r;
        logic [WORD_W-1:0] kw;
        n_queued = 0;

        // key schedule first: every entry written before any encrypt reads it,
        // entry 0 all zeros and entry 1 all ones, the last entry at the top index
        for (int k = 0; k < KEY_DEPTH; k++) begin
            if (k == 0)      kw = '0;
            else if (k == 1) kw = '1;
            else             kw = $urandom;
            push_cmd(OP_LOAD, k[KEY_IDX_W-1:0], kw, $urandom, $urandom);
        end
        // loads past the table end, with noise on the unused words; must not stick
        push_cmd(OP_LOAD, KEY_DEPTH[KEY_IDX_W-1:0], '1, '1, '1);
        push_cmd(OP_LOAD, '1, 32'hdead_beef, '1, '0);
        // plaintext extremes; key fields on an encrypt are don't-care
        push_cmd(OP_ENCRYPT, '0, '0, '0, '0);
        push_cmd(OP_ENCRYPT, '1, '1, '1, '1);
        push_cmd(OP_ENCRYPT, 6'd17, 32'h5555_aaaa, '0, '1);
        push_cmd(OP_ENCRYPT, '0, '0, 32'h8000_0000, 32'h0000_0001);
        push_cmd(OP_ENCRYPT, '1, '1, 32'h0123_4567, 32'h89ab_cdef);
        // overwrite a live entry and use it at once, then let the pipe run dry
        push_cmd(OP_LOAD, '0, '1, '0, '0);
        push_cmd(OP_ENCRYPT, '0, '0, '1, '0);
        push_drain();
        n_queued = KEY_DEPTH + 6;

        // random part: mostly encrypts, some re-keying, a few dropped loads
        while (n_queued < N_ITEMS) begin
            r = $urandom_range(99);
            if (r < 3) begin
                // full re-key sequence
                for (int k = 0; k < KEY_DEPTH; k++)
                    push_cmd(OP_LOAD, k[KEY_IDX_W-1:0], $urandom, $urandom, $urandom);
                n_queued += KEY_DEPTH;
            end else if (r < 13) begin
                push_cmd(OP_LOAD, KEY_IDX_W'($urandom_range(KEY_DEPTH - 1, 0)), $urandom,
                         $urandom, $urandom);
                n_queued++;
            end else if (r < 17) begin
                // ignored by the block, not counted
                push_cmd(OP_LOAD, KEY_IDX_W'($urandom_range(63, KEY_DEPTH)), $urandom,
                         $urandom, $urandom);
            end else begin
                push_cmd(OP_ENCRYPT, KEY_IDX_W'($urandom_range(63, 0)), $urandom,
                         $urandom, $urandom);
                n_queued++;
            end
            if ($urandom_range(249) == 0) push_drain();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_fifo.size() != 0 || i_valid || cipher_fifo.size() != 0)
            @(posedge i_clk);
        // let any trailing loads clear the chain and catch stray beats
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
